// ===== sv/svn_pkg.sv =====
// svn_pkg: shared types and constants of the smooth vertex normals unit
// item and result structs, opcodes, controller-to-datapath command and status
// no dependencies
package svn_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned AccumWidthDef  = 24;
  localparam int unsigned IdxW           = 10;
  localparam int unsigned PosW           = 32;
  localparam int unsigned NrmW           = 16;
  localparam int unsigned CountW         = 11;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [IdxW-1:0]        vertex_a;
    logic [IdxW-1:0]        vertex_b;
    logic [IdxW-1:0]        vertex_c;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0]        read_vertex;
    logic signed [NrmW-1:0] normal_x;
    logic signed [NrmW-1:0] normal_y;
    logic signed [NrmW-1:0] normal_z;
    logic                   zero_normal;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_CAPTURE, CMD_LOAD, CMD_POS_RD, CMD_POS_CAP,
    CMD_EDGE, CMD_ESHIFT, CMD_MUL, CMD_MACC, CMD_ACC_RD, CMD_VLOAD,
    CMD_NINIT, CMD_NSTEP, CMD_SQ, CMD_SQACC, CMD_SINIT, CMD_SSTEP,
    CMD_DINIT, CMD_DSTEP, CMD_DEND, CMD_ACC_WR, CMD_SET_ZERO, CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic zero;
    logic norm_ok;
    logic tri_ok;
    logic in_range;
  } sts_t;

endpackage

// ===== sv/svn_ctrl.sv =====
// svn_ctrl: sequencing state machine of the smooth vertex normals unit
// issues one datapath command per cycle, counts loop steps
// depends on svn_pkg
module svn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  svn_pkg::op_e  op_i,
  input  svn_pkg::sts_t sts_i,
  output svn_pkg::cmd_t cmd_o,
  output logic          busy
);

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_CLEAR  = 25'h0000002,
    S_LOAD   = 25'h0000004,
    S_TCHK   = 25'h0000008,
    S_PRD    = 25'h0000010,
    S_PCAP   = 25'h0000020,
    S_EDGE   = 25'h0000040,
    S_ESHIFT = 25'h0000080,
    S_MUL    = 25'h0000100,
    S_MACC   = 25'h0000200,
    S_RCHK   = 25'h0000400,
    S_RARD   = 25'h0000800,
    S_RALD   = 25'h0001000,
    S_NINIT  = 25'h0002000,
    S_NORM   = 25'h0004000,
    S_SQ     = 25'h0008000,
    S_SQACC  = 25'h0010000,
    S_SINIT  = 25'h0020000,
    S_SSTEP  = 25'h0040000,
    S_DINIT  = 25'h0080000,
    S_DSTEP  = 25'h0100000,
    S_DEND   = 25'h0200000,
    S_ARD    = 25'h0400000,
    S_AWR    = 25'h0800000,
    S_OUT    = 25'h1000000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [2:0] k_q, k_d;
  logic       tri_q, tri_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      k_q     <= '0;
      tri_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      tri_q   <= tri_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    tri_d      = tri_q;
    cmd_o.op   = svn_pkg::CMD_NONE;
    cmd_o.sel  = 3'd0;
    case (state_q)
      S_IDLE: begin
        cnt_d = 5'd0;
        k_d   = 3'd0;
        if (start) begin
          cmd_o.op = svn_pkg::CMD_CAPTURE;
          case (op_i)
            svn_pkg::OP_LOAD: state_d = S_LOAD;
            svn_pkg::OP_TRI:  begin state_d = S_TCHK; tri_d = 1'b1; end
            svn_pkg::OP_READ: begin state_d = S_RCHK; tri_d = 1'b0; end
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.op = svn_pkg::CMD_CLEAR;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_LOAD: begin
        cmd_o.op = svn_pkg::CMD_LOAD;
        state_d  = S_IDLE;
      end
      S_TCHK: begin
        state_d = sts_i.tri_ok ? S_PRD : S_IDLE;
      end
      S_PRD: begin
        cmd_o.op  = svn_pkg::CMD_POS_RD;
        cmd_o.sel = k_q;
        state_d   = S_PCAP;
      end
      S_PCAP: begin
        cmd_o.op  = svn_pkg::CMD_POS_CAP;
        cmd_o.sel = k_q;
        if (k_q == 3'd2) begin
          k_d     = 3'd0;
          state_d = S_EDGE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_PRD;
        end
      end
      S_EDGE: begin
        cmd_o.op = svn_pkg::CMD_EDGE;
        state_d  = S_ESHIFT;
      end
      S_ESHIFT: begin
        cmd_o.op = svn_pkg::CMD_ESHIFT;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op  = svn_pkg::CMD_MUL;
        cmd_o.sel = k_q;
        state_d   = S_MACC;
      end
      S_MACC: begin
        cmd_o.op  = svn_pkg::CMD_MACC;
        cmd_o.sel = k_q;
        if (k_q == 3'd5) begin
          k_d     = 3'd0;
          state_d = S_NINIT;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_RCHK: begin
        if (sts_i.in_range) begin
          state_d = S_RARD;
        end else begin
          cmd_o.op = svn_pkg::CMD_SET_ZERO;
          state_d  = S_OUT;
        end
      end
      S_RARD: begin
        cmd_o.op  = svn_pkg::CMD_ACC_RD;
        cmd_o.sel = 3'd0;
        state_d   = S_RALD;
      end
      S_RALD: begin
        cmd_o.op = svn_pkg::CMD_VLOAD;
        state_d  = S_NINIT;
      end
      S_NINIT: begin
        cmd_o.op = svn_pkg::CMD_NINIT;
        state_d  = S_NORM;
      end
      S_NORM: begin
        k_d = 3'd0;
        if (sts_i.zero) begin
          state_d = tri_q ? S_ARD : S_OUT;
        end else if (sts_i.norm_ok) begin
          state_d = S_SQ;
        end else begin
          cmd_o.op = svn_pkg::CMD_NSTEP;
        end
      end
      S_SQ: begin
        cmd_o.op  = svn_pkg::CMD_SQ;
        cmd_o.sel = k_q;
        state_d   = S_SQACC;
      end
      S_SQACC: begin
        cmd_o.op = svn_pkg::CMD_SQACC;
        if (k_q == 3'd2) begin
          k_d     = 3'd0;
          state_d = S_SINIT;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_SQ;
        end
      end
      S_SINIT: begin
        cmd_o.op = svn_pkg::CMD_SINIT;
        cnt_d    = 5'd0;
        state_d  = S_SSTEP;
      end
      S_SSTEP: begin
        cmd_o.op = svn_pkg::CMD_SSTEP;
        if (cnt_q == 5'd22) begin
          cnt_d   = 5'd0;
          state_d = S_DINIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_DINIT: begin
        cmd_o.op  = svn_pkg::CMD_DINIT;
        cmd_o.sel = k_q;
        cnt_d     = 5'd0;
        state_d   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = svn_pkg::CMD_DSTEP;
        if (cnt_q == 5'd14) begin
          cnt_d   = 5'd0;
          state_d = S_DEND;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_DEND: begin
        cmd_o.op  = svn_pkg::CMD_DEND;
        cmd_o.sel = k_q;
        if (k_q == 3'd2) begin
          k_d     = 3'd0;
          state_d = tri_q ? S_ARD : S_OUT;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_DINIT;
        end
      end
      S_ARD: begin
        cmd_o.op  = svn_pkg::CMD_ACC_RD;
        cmd_o.sel = k_q;
        state_d   = S_AWR;
      end
      S_AWR: begin
        cmd_o.op  = svn_pkg::CMD_ACC_WR;
        cmd_o.sel = k_q;
        if (k_q == 3'd2) begin
          k_d     = 3'd0;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_ARD;
        end
      end
      S_OUT: begin
        cmd_o.op = svn_pkg::CMD_OUT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/svn_dp.sv =====
// svn_dp: datapath of the smooth vertex normals unit
// position and accumulator memories, shared multiplier, normalize, sqrt, divide
// depends on svn_pkg, driven by svn_ctrl commands
module svn_dp #(
  parameter int unsigned MAX_VERTICES = svn_pkg::MaxVerticesDef,
  parameter int unsigned ACCUM_WIDTH  = svn_pkg::AccumWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  svn_pkg::cmd_t                cmd_i,
  input  svn_pkg::in_t                 item_i,
  input  logic                         cfg_we_i,
  input  logic [svn_pkg::CountW-1:0]   cfg_wdata_i,
  output svn_pkg::sts_t                sts_o,
  output svn_pkg::out_t                result_o,
  output logic                         result_valid_o
);

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned PW  = svn_pkg::PosW;
  localparam int unsigned NW  = svn_pkg::NrmW;
  localparam int unsigned SW  = ACCUM_WIDTH + 1;

  logic [3*PW-1:0]          pos_mem [MAX_VERTICES];
  logic [3*ACCUM_WIDTH-1:0] acc_mem [MAX_VERTICES];

  svn_pkg::in_t               item_q;
  logic [svn_pkg::CountW-1:0] vc_q;
  logic [AW-1:0]              clr_q;
  logic [3*PW-1:0]            pos_rd_q;
  logic [3*ACCUM_WIDTH-1:0]   acc_rd_q;

  logic signed [PW-1:0] p_q   [3][3];
  logic signed [PW:0]   dif_q [6];
  logic signed [PW-1:0] e_q   [6];
  logic signed [63:0]   prod_q;
  logic signed [63:0]   v_q   [3];
  logic [62:0]          mag_q [3];
  logic                 sgn_q [3];
  logic [62:0]          m_q;
  logic                 zero_q;
  logic [45:0]          sum_q, sx_q, sr_q, sb_q;
  logic [37:0]          rem_q, dv_q;
  logic [14:0]          quo_q;
  logic signed [NW-1:0] n_q   [3];
  svn_pkg::out_t        res_q;
  logic                 valid_q;

  logic [AW-1:0]            addr_a, addr_b, addr_c, addr_sel;
  logic                     a_in;
  logic                     pos_we, acc_we;
  logic [AW-1:0]            acc_waddr;
  logic [3*ACCUM_WIDTH-1:0] acc_wdata, acc_sat;
  logic signed [PW-1:0]     ma, mb;
  logic signed [63:0]       prod;
  logic [62:0]              nmag  [3];
  logic [62:0]              nmax;
  logic [PW-1:0]            emag  [6];
  logic [PW-1:0]            emax;
  logic [1:0]               esh;
  logic [45:0]              strial;

  assign addr_a = AW'(item_q.vertex_a);
  assign addr_b = AW'(item_q.vertex_b);
  assign addr_c = AW'(item_q.vertex_c);
  assign a_in   = 32'(item_q.vertex_a) < MAX_VERTICES;

  always_comb begin
    case (cmd_i.sel)
      3'd1:    addr_sel = addr_b;
      3'd2:    addr_sel = addr_c;
      default: addr_sel = addr_a;
    endcase
  end

  assign sts_o.clear_last = (32'(clr_q) == MAX_VERTICES - 1);
  assign sts_o.zero       = zero_q;
  assign sts_o.norm_ok    = (m_q[62:21] == '0) && m_q[20];
  assign sts_o.in_range   = a_in;
  assign sts_o.tri_ok     = a_in
                          && (32'(item_q.vertex_b) < MAX_VERTICES)
                          && (32'(item_q.vertex_c) < MAX_VERTICES)
                          && ({1'b0, item_q.vertex_a} < vc_q)
                          && ({1'b0, item_q.vertex_b} < vc_q)
                          && ({1'b0, item_q.vertex_c} < vc_q);

  // saturating add of the face normal to one accumulator entry
  always_comb begin
    logic signed [SW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      s = SW'($signed(acc_rd_q[i*ACCUM_WIDTH +: ACCUM_WIDTH])) + SW'(n_q[i]);
      if (s[SW-1] != s[SW-2]) begin
        acc_sat[i*ACCUM_WIDTH +: ACCUM_WIDTH] = {s[SW-1], {(ACCUM_WIDTH-1){~s[SW-1]}}};
      end else begin
        acc_sat[i*ACCUM_WIDTH +: ACCUM_WIDTH] = s[ACCUM_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    pos_we    = (cmd_i.op == svn_pkg::CMD_LOAD) && a_in;
    acc_we    = 1'b0;
    acc_waddr = addr_a;
    acc_wdata = '0;
    case (cmd_i.op)
      svn_pkg::CMD_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_q;
      end
      svn_pkg::CMD_LOAD: begin
        acc_we = a_in;
      end
      svn_pkg::CMD_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = addr_sel;
        acc_wdata = acc_sat;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[addr_a] <= {item_q.pos_z, item_q.pos_y, item_q.pos_x};
    end
    if (cmd_i.op == svn_pkg::CMD_POS_RD) begin
      pos_rd_q <= pos_mem[addr_sel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (cmd_i.op == svn_pkg::CMD_ACC_RD) begin
      acc_rd_q <= acc_mem[addr_sel];
    end
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_i.op == svn_pkg::CMD_SQ) begin
      case (cmd_i.sel)
        3'd1:    ma = PW'(mag_q[1][20:0]);
        3'd2:    ma = PW'(mag_q[2][20:0]);
        default: ma = PW'(mag_q[0][20:0]);
      endcase
      mb = ma;
    end else begin
      case (cmd_i.sel)
        3'd0:    begin ma = e_q[1]; mb = e_q[5]; end
        3'd1:    begin ma = e_q[2]; mb = e_q[4]; end
        3'd2:    begin ma = e_q[2]; mb = e_q[3]; end
        3'd3:    begin ma = e_q[0]; mb = e_q[5]; end
        3'd4:    begin ma = e_q[0]; mb = e_q[4]; end
        default: begin ma = e_q[1]; mb = e_q[3]; end
      endcase
    end
  end
  assign prod = ma * mb;

  always_comb begin
    nmax = '0;
    for (int i = 0; i < 3; i++) begin
      nmag[i] = v_q[i][63] ? 63'(-v_q[i]) : v_q[i][62:0];
      if (nmag[i] > nmax) nmax = nmag[i];
    end
    emax = '0;
    for (int i = 0; i < 6; i++) begin
      emag[i] = dif_q[i][PW] ? PW'(-dif_q[i]) : dif_q[i][PW-1:0];
      if (emag[i] > emax) emax = emag[i];
    end
    esh = emax[PW-1] ? 2'd2 : (emax[PW-2] ? 2'd1 : 2'd0);
  end

  assign strial = sr_q + sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q    <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) vc_q <= cfg_wdata_i;
      if (cmd_i.op == svn_pkg::CMD_CLEAR) clr_q <= clr_q + 1'b1;
      valid_q <= (cmd_i.op == svn_pkg::CMD_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      svn_pkg::CMD_CAPTURE: item_q <= item_i;
      svn_pkg::CMD_POS_CAP: begin
        for (int j = 0; j < 3; j++) begin
          p_q[cmd_i.sel[1:0]][j] <= pos_rd_q[j*PW +: PW];
        end
      end
      svn_pkg::CMD_EDGE: begin
        for (int j = 0; j < 3; j++) begin
          dif_q[j]   <= (PW+1)'(p_q[1][j]) - (PW+1)'(p_q[0][j]);
          dif_q[j+3] <= (PW+1)'(p_q[2][j]) - (PW+1)'(p_q[0][j]);
        end
      end
      svn_pkg::CMD_ESHIFT: begin
        for (int i = 0; i < 6; i++) begin
          e_q[i] <= dif_q[i][PW] ? -$signed(emag[i] >> esh) : $signed(emag[i] >> esh);
        end
      end
      svn_pkg::CMD_MUL, svn_pkg::CMD_SQ: prod_q <= prod;
      svn_pkg::CMD_MACC: begin
        if (!cmd_i.sel[0]) begin
          v_q[cmd_i.sel[2:1]] <= prod_q;
        end else begin
          v_q[cmd_i.sel[2:1]] <= v_q[cmd_i.sel[2:1]] - prod_q;
        end
      end
      svn_pkg::CMD_VLOAD: begin
        for (int i = 0; i < 3; i++) begin
          v_q[i] <= 64'($signed(acc_rd_q[i*ACCUM_WIDTH +: ACCUM_WIDTH]));
        end
      end
      svn_pkg::CMD_NINIT: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= nmag[i];
          sgn_q[i] <= v_q[i][63];
          n_q[i]   <= '0;
        end
        m_q    <= nmax;
        zero_q <= (nmax == '0);
        sum_q  <= '0;
      end
      svn_pkg::CMD_NSTEP: begin
        if (m_q[62:20] == '0) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          m_q <= m_q << 1;
        end else begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          m_q <= m_q >> 1;
        end
      end
      svn_pkg::CMD_SQACC: sum_q <= sum_q + prod_q[45:0];
      svn_pkg::CMD_SINIT: begin
        sx_q <= sum_q;
        sr_q <= '0;
        sb_q <= 46'd1 << 44;
      end
      svn_pkg::CMD_SSTEP: begin
        if (sx_q >= strial) begin
          sx_q <= sx_q - strial;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      svn_pkg::CMD_DINIT: begin
        rem_q <= 38'({mag_q[cmd_i.sel[1:0]][20:0], 14'd0}) + 38'(sr_q[22:1]);
        dv_q  <= 38'(sr_q[22:0]) << 14;
        quo_q <= '0;
      end
      svn_pkg::CMD_DSTEP: begin
        if (rem_q >= dv_q) begin
          rem_q <= rem_q - dv_q;
          quo_q <= {quo_q[13:0], 1'b1};
        end else begin
          quo_q <= {quo_q[13:0], 1'b0};
        end
        dv_q <= dv_q >> 1;
      end
      svn_pkg::CMD_DEND: begin
        n_q[cmd_i.sel[1:0]] <= sgn_q[cmd_i.sel[1:0]] ? -$signed(NW'(quo_q))
                                                     : $signed(NW'(quo_q));
      end
      svn_pkg::CMD_SET_ZERO: begin
        for (int i = 0; i < 3; i++) n_q[i] <= '0;
        zero_q <= 1'b1;
      end
      svn_pkg::CMD_OUT: begin
        res_q.read_vertex <= item_q.vertex_a;
        res_q.normal_x    <= n_q[0];
        res_q.normal_y    <= n_q[1];
        res_q.normal_z    <= n_q[2];
        res_q.zero_normal <= zero_q;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign result_o       = res_q;
  assign result_valid_o = valid_q;

endmodule

// ===== sv/smooth_vertex_normals_unit.sv =====
// smooth_vertex_normals_unit: top level of the smooth vertex normals block
// holds svn_ctrl (sequencer) and svn_dp (memories and arithmetic)
// depends on svn_pkg
//
// Usage: an item beat is taken on the rising edge where start is high and
// busy is low, one item at a time. op load stores a position and clears that
// accumulator; op 3 is dropped. op triangle reads three positions, forms the
// cross product on one shared 32x32 multiplier, normalizes by one bit per
// cycle, takes the square root at one result bit per cycle, divides at one
// quotient bit per cycle and updates three accumulators. The result beat of
// op read sits on result_o for one cycle with result_valid_o high, in the
// first cycle with busy low. The receiver cannot stall. After reset the
// accumulator memory is cleared, one entry a cycle, with busy high;
// cfg_we_i writes vertex_count at any edge, and vertex_count resets to zero.
module smooth_vertex_normals_unit #(
  parameter int unsigned MAX_VERTICES = svn_pkg::MaxVerticesDef,
  parameter int unsigned ACCUM_WIDTH  = svn_pkg::AccumWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  svn_pkg::in_t               item_i,
  input  logic                       cfg_we_i,
  input  logic [svn_pkg::CountW-1:0] cfg_wdata_i,
  output svn_pkg::out_t              result_o,
  output logic                       result_valid_o
);

  svn_pkg::cmd_t cmd;
  svn_pkg::sts_t sts;

  svn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (item_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  svn_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .ACCUM_WIDTH  (ACCUM_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// ===== verif/tb_smooth_vertex_normals_unit.sv =====
`timescale 1ns / 100ps
// tb_smooth_vertex_normals_unit: self-checking bench for the smooth vertex normals unit
// scoreboard class with its own normal-averaging predictor, directed then random beats
// depends on svn_pkg and smooth_vertex_normals_unit
module tb_smooth_vertex_normals_unit;

  localparam int unsigned NumVert = svn_pkg::MaxVerticesDef;
  localparam int unsigned AccW    = svn_pkg::AccumWidthDef;
  localparam int unsigned IdxW    = svn_pkg::IdxW;
  localparam int unsigned CountW  = svn_pkg::CountW;
  localparam int unsigned Settle  = 200;

  class normal_scoreboard;
    longint pos_tab[NumVert][3];
    longint acc_tab[NumVert][3];
    int unsigned vert_limit;
    svn_pkg::out_t expected_q[$];
    int errs;
    int unsigned n_checked;

    function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // scale to unit length in q2.14, returns 1 for the zero vector
    function automatic bit unit_scale(input longint v[3], output longint n[3]);
      longint m, sum, len, w[3], q;
      int s;
      bit left;
      m = 0;
      s = 0;
      sum = 0;
      left = 0;
      for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
      if (m == 0) begin
        for (int i = 0; i < 3; i++) n[i] = 0;
        return 1;
      end
      if (m < (64'sd1 << 20)) begin
        left = 1;
        while (m < (64'sd1 << 20)) begin m = m << 1; s++; end
      end else begin
        while (m >= (64'sd1 << 21)) begin m = m >> 1; s++; end
      end
      for (int i = 0; i < 3; i++) begin
        w[i] = left ? (mag(v[i]) << s) : (mag(v[i]) >> s);
        if (v[i] < 0) w[i] = -w[i];
        sum += mag(w[i]) * mag(w[i]);
      end
      len = longint'(int_sqrt(sum));
      for (int i = 0; i < 3; i++) begin
        q = (mag(w[i]) * 16384 + len / 2) / len;
        n[i] = (w[i] < 0) ? -q : q;
      end
      return 0;
    endfunction

    function automatic longint sat_add(longint a, longint b);
      longint hi, lo, r;
      hi = (64'sd1 <<< (AccW - 1)) - 1;
      lo = -hi - 1;
      r = a + b;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r;
    endfunction

    function automatic void add_face(int a, int b, int c);
      longint e1[3], e2[3], cr[3], n[3], m;
      int s;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = pos_tab[b][i] - pos_tab[a][i];
        e2[i] = pos_tab[c][i] - pos_tab[a][i];
        if (mag(e1[i]) > m) m = mag(e1[i]);
        if (mag(e2[i]) > m) m = mag(e2[i]);
      end
      while (m >= (64'sd1 << 30)) begin m = m >> 1; s++; end
      for (int i = 0; i < 3; i++) begin
        e1[i] = (e1[i] < 0) ? -(mag(e1[i]) >> s) : (e1[i] >> s);
        e2[i] = (e2[i] < 0) ? -(mag(e2[i]) >> s) : (e2[i] >> s);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      void'(unit_scale(cr, n));
      for (int i = 0; i < 3; i++) begin
        acc_tab[a][i] = sat_add(acc_tab[a][i], n[i]);
        acc_tab[b][i] = sat_add(acc_tab[b][i], n[i]);
        acc_tab[c][i] = sat_add(acc_tab[c][i], n[i]);
      end
    endfunction

    function void set_count(int unsigned v);
      vert_limit = v;
    endfunction

    function void note_item(svn_pkg::in_t it);
      longint v[3], n[3];
      svn_pkg::out_t r;
      case (it.op)
        svn_pkg::OP_LOAD: begin
          pos_tab[it.vertex_a][0] = longint'(it.pos_x);
          pos_tab[it.vertex_a][1] = longint'(it.pos_y);
          pos_tab[it.vertex_a][2] = longint'(it.pos_z);
          for (int i = 0; i < 3; i++) acc_tab[it.vertex_a][i] = 0;
        end
        svn_pkg::OP_TRI: begin
          if (it.vertex_a < vert_limit && it.vertex_b < vert_limit &&
              it.vertex_c < vert_limit)
            add_face(int'(it.vertex_a), int'(it.vertex_b), int'(it.vertex_c));
        end
        svn_pkg::OP_READ: begin
          for (int i = 0; i < 3; i++) v[i] = acc_tab[it.vertex_a][i];
          r.zero_normal = unit_scale(v, n);
          r.read_vertex = it.vertex_a;
          r.normal_x = 16'(n[0]);
          r.normal_y = 16'(n[1]);
          r.normal_z = 16'(n[2]);
          expected_q = {expected_q, r};
        end
        default: ;
      endcase
    endfunction

    function void check(svn_pkg::out_t got);
      svn_pkg::out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat for vertex %0d", got.read_vertex);
        errs++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (got.read_vertex !== e.read_vertex) begin
        $error("read_vertex expected %0d got %0d", e.read_vertex, got.read_vertex);
        errs++;
      end
      if (got.normal_x !== e.normal_x) begin
        $error("normal_x expected %0d got %0d", e.normal_x, got.normal_x);
        errs++;
      end
      if (got.normal_y !== e.normal_y) begin
        $error("normal_y expected %0d got %0d", e.normal_y, got.normal_y);
        errs++;
      end
      if (got.normal_z !== e.normal_z) begin
        $error("normal_z expected %0d got %0d", e.normal_z, got.normal_z);
        errs++;
      end
      if (got.zero_normal !== e.zero_normal) begin
        $error("zero_normal expected %0d got %0d", e.zero_normal, got.zero_normal);
        errs++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  svn_pkg::in_t      item;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;
  svn_pkg::out_t     result;
  logic              result_valid;

  normal_scoreboard sb;
  bit               loaded[NumVert];
  bit               idle_on;
  int unsigned      cur_count;
  int unsigned      n_load, n_tri, n_read, n_cfg;

  smooth_vertex_normals_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .result_o      (result),
    .result_valid_o(result_valid)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid) sb.check(result);
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_beat(svn_pkg::in_t it);
    item  <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
    case (it.op)
      svn_pkg::OP_LOAD: begin loaded[it.vertex_a] = 1; n_load++; end
      svn_pkg::OP_TRI:  n_tri++;
      svn_pkg::OP_READ: n_read++;
      default: ;
    endcase
    if (idle_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_count(int unsigned v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CountW'(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_count(v);
    cur_count = v;
    n_cfg++;
  endtask

  function automatic svn_pkg::in_t mk(svn_pkg::op_e op, int a, int b, int c,
                                      int x, int y, int z);
    svn_pkg::in_t it;
    it.op = op;
    it.vertex_a = IdxW'(a);
    it.vertex_b = IdxW'(b);
    it.vertex_c = IdxW'(c);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(9))
      0: return int'($urandom);
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return int'($urandom) >>> $urandom_range(4, 24);
    endcase
  endfunction

  function automatic int pick_idx();
    int unsigned span;
    span = (cur_count < 8) ? 8 : ((cur_count > 48) ? 48 : cur_count);
    if ($urandom_range(19) == 0) return $urandom_range(1023);
    return $urandom_range(span - 1);
  endfunction

  // a triangle within the vertex count that would touch an unloaded position becomes a load of it
  function automatic svn_pkg::in_t legalize(svn_pkg::in_t it);
    int idx[3];
    idx = '{int'(it.vertex_a), int'(it.vertex_b), int'(it.vertex_c)};
    if (it.op != svn_pkg::OP_TRI) return it;
    if (idx[0] >= cur_count || idx[1] >= cur_count || idx[2] >= cur_count) return it;
    foreach (idx[i]) begin
      if (!loaded[idx[i]]) begin
        it.op = svn_pkg::OP_LOAD;
        it.vertex_a = IdxW'(idx[i]);
        return it;
      end
    end
    return it;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned n_items, bit pile);
    svn_pkg::in_t it;
    int unsigned r;
    write_count(count);
    for (int unsigned k = 0; k < n_items; k++) begin
      idle_on = !(k >= n_items / 3 && k < n_items / 2);
      r = $urandom_range(99);
      it = mk(svn_pkg::OP_NOP, pick_idx(), pick_idx(), pick_idx(),
              rand_coord(), rand_coord(), rand_coord());
      if (pile) begin
        if (r < 90) it = mk(svn_pkg::OP_TRI, 0, 1, 2, it.pos_x, it.pos_y, it.pos_z);
        else it.op = svn_pkg::OP_READ;
      end else if (r < 25) it.op = svn_pkg::OP_LOAD;
      else if (r < 70) it.op = svn_pkg::OP_TRI;
      else if (r < 95) it.op = svn_pkg::OP_READ;
      else it.op = svn_pkg::OP_NOP;
      send_beat(legalize(it));
    end
  endtask

  initial begin
    sb = new();
    sb.set_count(0);
    cur_count = 0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed beats
    write_count(1024);
    send_beat(mk(svn_pkg::OP_READ, 1023, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_LOAD, 1, 0, 0, 32'h0001_0000, 0, 0));
    send_beat(mk(svn_pkg::OP_LOAD, 2, 0, 0, 0, 32'h0001_0000, 0));
    send_beat(mk(svn_pkg::OP_LOAD, 3, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_beat(mk(svn_pkg::OP_LOAD, 4, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send_beat(mk(svn_pkg::OP_LOAD, 1023, 1023, 1023, -1, 32'h5555_5555, 32'haaaa_aaaa));
    send_beat(mk(svn_pkg::OP_TRI, 0, 1, 2, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_TRI, 3, 4, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_TRI, 1023, 3, 4, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_TRI, 0, 1, 1, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_READ, 3, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_READ, 1023, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_READ, 1, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_NOP, 1023, 1023, 1023, -1, -1, -1));
    send_beat(mk(svn_pkg::OP_LOAD, 3, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_beat(mk(svn_pkg::OP_READ, 3, 0, 0, 0, 0, 0));
    write_count(2);
    send_beat(mk(svn_pkg::OP_TRI, 0, 1, 2, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    write_count(0);
    send_beat(mk(svn_pkg::OP_TRI, 0, 0, 0, 0, 0, 0));
    send_beat(mk(svn_pkg::OP_READ, 0, 0, 0, 0, 0, 0));

    // same face piled up until the accumulators clip
    random_phase(3, 600, 1);
    random_phase(1024, 300, 0);
    random_phase(0, 150, 0);
    random_phase(37, 300, 0);
    random_phase(1, 100, 0);
    random_phase(300, 200, 0);
    random_phase(1024, 300, 0);
    drain();

    $display("covered %0d loads, %0d triangles, %0d reads, %0d count writes",
             n_load, n_tri, n_read, n_cfg);
    $display("checked %0d result beats, %0d mismatches", sb.n_checked, sb.errs);
    if (sb.errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/svn_pkg.sv
sv/svn_ctrl.sv
sv/svn_dp.sv
sv/smooth_vertex_normals_unit.sv
verif/tb_smooth_vertex_normals_unit.sv
